// ----- rtl/core/fir_circ_pkg.sv -----
package fir_circ_pkg;

  // Default sizing
  localparam int MAX_TAPS_DEF    = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths
  localparam int CMD_W   = 2;
  localparam int TAP_W   = 6;
  localparam int INDEX_W = 6;

  // Number of coefficient slots that the index field can name
  localparam int INDEX_SPAN = 1 << INDEX_W;

  // Tap count register after reset
  localparam logic [TAP_W-1:0] TAP_RESET = 6'd63;

  // Item kinds carried in tuser
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COEF   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic start;      // sample accepted: write history, arm the walk
    logic load_coef;  // coefficient item accepted
    logic clear;      // clear item accepted
    logic issue;      // read one tap pair
    logic finish;     // round the sum into the output register
  } fc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_tap;   // tap being read is the final one
    logic out_free;   // output register can take a new result
  } fc_stat_t;

endpackage

// ----- rtl/core/fir_filter_circular_core.sv -----
// A sample item walks the n taps in use (63 after reset); the single multiply-accumulate
// unit reads one history entry and one coefficient per cycle, and the sum is then rounded
// into the output register. Coefficient and clear items are taken while idle; no new
// item is taken until a sample's result has entered the output register.
// Reset (rst, synchronous): empties both stores through per-entry valid bits, clears
// the write pointer, sets tap_count to 63; no clearing pass is needed.
module fir_filter_circular_core
  import fir_circ_pkg::*;
#(
  parameter int MAX_TAPS    = MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IN_W       = ((2 * SAMPLE_BITS + INDEX_W + 7) / 8) * 8,
  localparam int OUT_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // input items
  input  logic             s_tvalid,
  output logic             s_tready,
  // sample_in, coeff_index, coeff_value, zero padding
  input  logic [IN_W-1:0]  s_tdata,
  // cmd
  input  logic [CMD_W-1:0] s_tuser,
  // result items
  output logic             m_tvalid,
  input  logic             m_tready,
  // sample_out, zero padding
  output logic [OUT_W-1:0] m_tdata,
  // tap_count register write
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TAP_W-1:0] cfg_data
);

  localparam int SB = SAMPLE_BITS;

  fc_cmd_t              cmd;
  fc_stat_t             stat;
  logic signed [SB-1:0] sample_in;
  logic [INDEX_W-1:0]   coeff_index;
  logic signed [SB-1:0] coeff_value;
  logic [SB-1:0]        sample_out;

  // Unpack the item: sample in the lowest bits, then slot, then coefficient
  assign sample_in   = s_tdata[SB-1:0];
  assign coeff_index = s_tdata[SB+INDEX_W-1:SB];
  assign coeff_value = s_tdata[2*SB+INDEX_W-1:SB+INDEX_W];

  // Pad the result up to whole bytes
  assign m_tdata = OUT_W'(sample_out);

  // Sequencer: takes items only when idle, walks the taps, waits on the output
  fir_circ_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Stores, pointer, multiply-accumulate, rounding and the output register
  fir_circ_dp #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .sample_in   (sample_in),
    .coeff_index (coeff_index),
    .coeff_value (coeff_value),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .sample_out  (sample_out)
  );

endmodule

// ----- rtl/core/fir_circ_ctrl.sv -----
module fir_circ_ctrl
  import fir_circ_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic [CMD_W-1:0] s_tuser,
  output logic             s_tready,
  input  fc_stat_t         stat,
  output fc_cmd_t          cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND
  } state_t;

  state_t state;
  logic   drain_cnt;
  logic   accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd.start     = accept && (s_tuser == CMD_SAMPLE);
    cmd.load_coef = accept && (s_tuser == CMD_COEF);
    cmd.clear     = accept && (s_tuser == CMD_CLEAR);
    cmd.issue     = (state == ST_MAC);
    cmd.finish    = (state == ST_ROUND) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      drain_cnt <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.start) begin
            state <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (stat.last_tap) begin
            state     <= ST_DRAIN;
            drain_cnt <= 1'b0;
          end
        end
        ST_DRAIN: begin
          // wait for the read and product stages to empty
          if (drain_cnt) begin
            state <= ST_ROUND;
          end
          drain_cnt <= 1'b1;
        end
        ST_ROUND: begin
          if (stat.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/fir_circ_dp.sv -----
module fir_circ_dp
  import fir_circ_pkg::*;
#(
  parameter int MAX_TAPS    = MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fc_cmd_t                       cmd,
  output fc_stat_t                      stat,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic [INDEX_W-1:0]            coeff_index,
  input  logic signed [SAMPLE_BITS-1:0] coeff_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [TAP_W-1:0]              cfg_data,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [SAMPLE_BITS-1:0]        sample_out
);

  localparam int PW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int NW    = $clog2(MAX_TAPS + 1);
  localparam int SB    = SAMPLE_BITS;
  localparam int FRAC  = SB - 1;
  localparam int PRODW = 2 * SB;
  localparam int ACC_W = PRODW + PW + 1;
  localparam int TAP_RESET_ODD = int'(TAP_RESET) | 1;
  localparam int N_RESET = (TAP_RESET_ODD > MAX_TAPS) ? MAX_TAPS : TAP_RESET_ODD;

  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};
  localparam logic signed [ACC_W-1:0] MAXV =
    {{(ACC_W - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] MINV = ~MAXV;

  // configuration and walk control
  logic [TAP_W-1:0] tap_count;
  logic [NW-1:0]    n_taps;
  logic [NW-1:0]    n_eff;
  logic [PW-1:0]    wp;
  logic [PW-1:0]    wp_next;
  logic [PW-1:0]    hist_idx;
  logic [PW-1:0]    tap;
  logic [PW-1:0]    n_last;

  // storage
  logic [SB-1:0]    hist_mem [MAX_TAPS];
  logic [SB-1:0]    coef_mem [MAX_TAPS];
  logic             hist_vld [MAX_TAPS];
  logic             coef_vld [MAX_TAPS];
  logic [PW-1:0]    slot_lut [INDEX_SPAN];
  logic [PW-1:0]    slot;

  // multiply-accumulate pipe
  logic [SB-1:0]           hist_q;
  logic [SB-1:0]           coef_q;
  logic                    hv_q;
  logic                    cv_q;
  logic                    rd_v;
  logic signed [SB-1:0]    hist_op;
  logic signed [SB-1:0]    coef_op;
  logic signed [PRODW-1:0] prod;
  logic                    prod_v;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] clamped;

  assign cfg_ready = 1'b1;

  // Index to slot, reduced modulo the store depth
  for (genvar g = 0; g < INDEX_SPAN; g++) begin : g_slot
    localparam int SLOT = g % MAX_TAPS;
    assign slot_lut[g] = PW'(SLOT);
  end
  assign slot = slot_lut[coeff_index];

  always_comb begin
    if ((int'(tap_count) | 1) > MAX_TAPS) begin
      n_eff = NW'(MAX_TAPS);
    end else begin
      n_eff = NW'(tap_count | TAP_W'(1));
    end
  end

  assign n_last        = PW'(n_taps - NW'(1));
  assign wp_next       = (NW'(wp) + NW'(1) == n_taps) ? '0 : PW'(wp + PW'(1));
  assign stat.last_tap = (tap == n_last);
  assign stat.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_RESET;
      n_taps    <= NW'(N_RESET);
      wp        <= '0;
    end else begin
      if (cfg_valid) begin
        tap_count <= cfg_data;
      end
      if (cmd.clear) begin
        n_taps <= n_eff;
        wp     <= '0;
      end else if (cmd.start) begin
        wp <= wp_next;
      end
    end
  end

  // tap walk: coefficients forward, history backward
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tap      <= '0;
      hist_idx <= wp;
    end else if (cmd.issue) begin
      tap      <= PW'(tap + PW'(1));
      hist_idx <= (hist_idx == '0) ? n_last : PW'(hist_idx - PW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hist_mem[wp] <= sample_in;
    end
    if (cmd.issue) begin
      hist_q <= hist_mem[hist_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_coef) begin
      coef_mem[slot] <= coeff_value;
    end
    if (cmd.issue) begin
      coef_q <= coef_mem[tap];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        hist_vld[i] <= 1'b0;
        coef_vld[i] <= 1'b0;
      end
    end else begin
      if (cmd.clear) begin
        for (int i = 0; i < MAX_TAPS; i++) begin
          hist_vld[i] <= 1'b0;
        end
      end else if (cmd.start) begin
        hist_vld[wp] <= 1'b1;
      end
      if (cmd.load_coef) begin
        coef_vld[slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      hv_q <= hist_vld[hist_idx];
      cv_q <= coef_vld[tap];
    end
  end

  // history entries never written since reset or clear, and coefficient entries never written since reset, read as zero
  assign hist_op = hv_q ? hist_q : '0;
  assign coef_op = cv_q ? coef_q : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v   <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      rd_v   <= cmd.issue;
      prod_v <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v) begin
      prod <= hist_op * coef_op;
    end
    if (cmd.start) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // round half up, then saturate
  always_comb begin
    rnd = (acc + HALF) >>> FRAC;
    if (rnd > MAXV) begin
      clamped = MAXV;
    end else if (rnd < MINV) begin
      clamped = MINV;
    end else begin
      clamped = rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      sample_out <= clamped[SB-1:0];
    end
  end

endmodule

// ----- rtl/core/fir_circ_checker.sv -----
module fir_circ_checker
  import fir_circ_pkg::*;
#(
  parameter int OUT_W = 16
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [CMD_W-1:0] s_tuser,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // the block goes busy only after taking a sample item
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(s_tready) && !$past(rst) |->
      $past(s_tvalid) && ($past(s_tuser) == CMD_SAMPLE))
    else $error("input stalled without a sample item");

  // a new result only appears at the end of a busy spell
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared while idle");

  // ending a busy spell always leaves a result
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $rose(s_tready) && !$past(rst) |-> m_tvalid)
    else $error("sample finished without a result");

endmodule

bind fir_filter_circular_core fir_circ_checker #(
  .OUT_W (OUT_W)
) u_fir_circ_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- dv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fir_circ_pkg::*;

  localparam int SMP_W = SAMPLE_BITS_DEF;
  localparam int IN_W  = ((2 * SMP_W + INDEX_W + 7) / 8) * 8;
  localparam int OUT_W = ((SMP_W + 7) / 8) * 8;

  // Longest sample walk is 63 taps plus the pipeline drain; allow extra
  localparam int SETTLE_CYCLES = 80;
  // Long receiver hold-off, long enough to back the block up onto its input
  localparam int LONG_HOLD     = 300;

  localparam longint SAT_HI = (longint'(1) << (SMP_W - 1)) - 1;
  localparam longint SAT_LO = -(longint'(1) << (SMP_W - 1));

  // Item kind the block must ignore
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [SMP_W-1:0] sample;
    logic [INDEX_W-1:0]      cidx;
    logic signed [SMP_W-1:0] cval;
  } fir_item_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata   = '0;   // sample_in, coeff_index, coeff_value, zero padding
  logic [CMD_W-1:0] s_tuser   = '0;   // cmd
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [OUT_W-1:0] m_tdata;          // sample_out
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [TAP_W-1:0] cfg_data  = '0;

  fir_filter_circular_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Items waiting to be offered, and filtered samples still owed by the block
  fir_item_t               item_q[$];
  logic signed [SMP_W-1:0] expected_out_q[$];
  int                      mismatch_count = 0;

  // Handshake bookkeeping shared between the clocked processes
  logic took_item = 1'b0;
  int   send_idle_pct = 37;
  int   recv_idle_pct = 58;
  int   holds_asked = 0;
  int   holds_served = 0;
  int   hold_left = 0;

  // Own copy of the filter state
  logic signed [SMP_W-1:0] history [MAX_TAPS_DEF];
  logic signed [SMP_W-1:0] coeffs  [MAX_TAPS_DEF];
  int unsigned             wr_ptr;
  int unsigned             taps_live;
  logic [TAP_W-1:0]        taps_reg;

  // Even requests round up to odd, zero becomes one, never beyond the store
  function automatic int unsigned live_taps(input logic [TAP_W-1:0] req);
    int unsigned t;
    t = int'(req) | 1;
    if (t > MAX_TAPS_DEF) t = MAX_TAPS_DEF;
    return t;
  endfunction

  task automatic reset_filter_state();
    for (int i = 0; i < MAX_TAPS_DEF; i++) begin
      history[i] = '0;
      coeffs[i]  = '0;
    end
    wr_ptr    = 0;
    taps_reg  = TAP_RESET;
    taps_live = live_taps(TAP_RESET);
  endtask

  // Apply one accepted item to the filter state; queue the output it owes
  task automatic step_filter(input fir_item_t it);
    int unsigned             n;
    int unsigned             base;
    int unsigned             idx;
    longint                  acc;
    longint                  rounded;
    logic signed [SMP_W-1:0] res;
    case (it.cmd)
      CMD_COEF: coeffs[it.cidx % MAX_TAPS_DEF] = it.cval;
      CMD_CLEAR: begin
        for (int i = 0; i < MAX_TAPS_DEF; i++) history[i] = '0;
        wr_ptr    = 0;
        taps_live = live_taps(taps_reg);
      end
      CMD_SAMPLE: begin
        n    = taps_live;
        base = wr_ptr % n;
        idx  = base;
        history[idx] = it.sample;
        acc = 0;
        // newest sample meets coefficient 0, stepping back through the ring
        for (int unsigned i = 0; i < n; i++) begin
          acc += longint'(history[idx]) * longint'(coeffs[i]);
          idx = (idx == 0) ? n - 1 : idx - 1;
        end
        // add half an LSB, floor, then clamp to the sample range
        rounded = (acc + (longint'(1) << (SMP_W - 2))) >>> (SMP_W - 1);
        if (rounded > SAT_HI) rounded = SAT_HI;
        if (rounded < SAT_LO) rounded = SAT_LO;
        res = rounded[SMP_W-1:0];
        expected_out_q.push_back(res);
        wr_ptr = base + 1;
        if (wr_ptr >= n) wr_ptr = 0;
      end
      CMD_SPARE: ;
    endcase
  endtask

  // Sample every handshake at the rising edge: config writes, input items, results
  always @(posedge clk) begin : watch_ports
    fir_item_t               seen;
    logic signed [SMP_W-1:0] want;
    if (rst) begin
      reset_filter_state();
      took_item <= 1'b0;
    end else begin
      took_item <= s_tvalid && s_tready;
      if (cfg_valid && cfg_ready) taps_reg = cfg_data;
      if (s_tvalid && s_tready) begin
        seen.cmd    = s_tuser;
        seen.sample = s_tdata[SMP_W-1:0];
        seen.cidx   = s_tdata[SMP_W +: INDEX_W];
        seen.cval   = s_tdata[SMP_W + INDEX_W +: SMP_W];
        step_filter(seen);
      end
      if (m_tvalid && m_tready) begin
        if (expected_out_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual %0d",
                   $time, $signed(m_tdata[SMP_W-1:0]));
        end else begin
          want = expected_out_q.pop_front();
          if (m_tdata !== OUT_W'(want)) begin
            mismatch_count++;
            $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                     $time, want, $signed(m_tdata[SMP_W-1:0]));
          end
        end
      end
    end
  end

  // Offer items on the falling edge; hold an offered item until it is taken
  always @(negedge clk) begin : drive_items
    fir_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || took_item) begin
      if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = item_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= nxt.cmd;
        s_tdata  <= IN_W'({nxt.cval, nxt.cidx, nxt.sample});
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off when one is asked for
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_served + 1;
      hold_left    <= LONG_HOLD;
      m_tready     <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [SMP_W-1:0] pick_q15();
    int unsigned v;
    case ($urandom_range(7))
      0:       v = 32'h0000_7fff;
      1:       v = 32'h0000_8000;
      2, 3:    v = $urandom;
      default: v = $urandom_range(8191) - 4096;
    endcase
    return v[SMP_W-1:0];
  endfunction

  function automatic fir_item_t random_item();
    fir_item_t   it;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 62)      it.cmd = CMD_SAMPLE;
    else if (r < 88) it.cmd = CMD_COEF;
    else if (r < 94) it.cmd = CMD_CLEAR;
    else             it.cmd = CMD_SPARE;
    it.sample = pick_q15();
    it.cidx   = INDEX_W'($urandom_range(INDEX_SPAN - 1));
    it.cval   = pick_q15();
    return it;
  endfunction

  task automatic push_item(input logic [CMD_W-1:0] cmd, input int sample,
                           input int cidx, input int cval);
    fir_item_t it;
    it.cmd    = cmd;
    it.sample = sample[SMP_W-1:0];
    it.cidx   = cidx[INDEX_W-1:0];
    it.cval   = cval[SMP_W-1:0];
    item_q.push_back(it);
  endtask

  // Write tap_count, then hand back on a rising edge so queue pushes stay clear
  // of the driver
  task automatic write_taps(input logic [TAP_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every item to be taken and every result to arrive, then let an
  // ignored or loading item finish inside the block
  task automatic wait_quiet();
    while (item_q.size() != 0 || s_tvalid || expected_out_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned tap_plan [9];
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed run at the reset tap count of 63
    push_item(CMD_SAMPLE, 32767, 0, 0);          // all coefficients still zero
    push_item(CMD_COEF, 0, 0, 16384);
    push_item(CMD_COEF, 0, 1, 16384);
    push_item(CMD_CLEAR, 0, 0, 0);
    push_item(CMD_SAMPLE, 1, 0, 0);              // exact half LSB rounds up
    push_item(CMD_CLEAR, 0, 0, 0);
    push_item(CMD_SAMPLE, -1, 0, 0);             // minus half LSB rounds to zero
    push_item(CMD_COEF, 0, 63, -32768);          // top slot, outside the 63 taps
    push_item(CMD_COEF, 0, 0, 32767);
    push_item(CMD_COEF, 0, 1, 32767);
    push_item(CMD_COEF, 0, 2, 32767);
    push_item(CMD_SAMPLE, 32767, 0, 0);
    push_item(CMD_SAMPLE, 32767, 0, 0);
    push_item(CMD_SAMPLE, 32767, 0, 0);          // clamps at the top
    push_item(CMD_SAMPLE, -32768, 0, 0);
    push_item(CMD_SAMPLE, -32768, 0, 0);
    push_item(CMD_SAMPLE, -32768, 0, 0);         // clamps at the bottom
    push_item(CMD_COEF, 0, 0, -32768);
    push_item(CMD_SAMPLE, -32768, 0, 0);         // most negative squared
    push_item(CMD_SPARE, -1, 63, -1);            // ignored kind, all field bits set
    push_item(CMD_SAMPLE, 0, 0, 0);
    push_item(CMD_CLEAR, -1, 63, -1);
    push_item(CMD_SAMPLE, 12345, 0, 0);
    wait_quiet();

    // Tap counts to sweep: both extremes, even values, and a few random ones
    tap_plan = '{0, 63, 2, 62, $urandom_range(63), 1,
                 $urandom_range(63), $urandom_range(15), 63};

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 37; recv_idle_pct = 58; end
        1: begin send_idle_pct = 58; recv_idle_pct = 37; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int rd = 0; rd < 3; rd++) begin
        write_taps(TAP_W'(tap_plan[ph * 3 + rd]));
        // Skip the clear in one round so the old tap count must stay in force
        if (rd != 2) push_item(CMD_CLEAR, 0, 0, 0);
        if (ph == 0 && rd == 0) begin
          // Stall the receiver for a long stretch while samples keep coming
          holds_asked++;
          repeat (24) push_item(CMD_SAMPLE, $urandom, 0, 0);
        end
        repeat (40) item_q.push_back(random_item());
        wait_quiet();
      end
    end

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
